>>> src/gzip_member_header_trailer_checker_defines.svh
// ----------------------------------------------------------------------------
// gzip member checker assertion macros
// shared property forms, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef GZIP_MEMBER_HEADER_TRAILER_CHECKER_DEFINES_SVH
`define GZIP_MEMBER_HEADER_TRAILER_CHECKER_DEFINES_SVH

// same-cycle implication
`define GZMHC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GZMHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/gzmhc_pkg.sv
// ----------------------------------------------------------------------------
// gzmhc_pkg
// types and codes shared by the gzip member framing checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gzmhc_pkg;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } gzmhc_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] error_code;
  } gzmhc_out_t;

  // one request handed from the input register to the framing stage
  typedef struct packed {
    logic      fire;
    gzmhc_in_t item;
  } gzmhc_step_t;

  // item kinds
  localparam logic [1:0] OP_CONTAINER = 2'd0;
  localparam logic [1:0] OP_PAYLOAD   = 2'd1;
  localparam logic [1:0] OP_BODY_END  = 2'd2;
  localparam logic [1:0] OP_INPUT_END = 2'd3;

  // result status
  localparam logic [1:0] ST_MORE   = 2'd0;
  localparam logic [1:0] ST_HEADER = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;
  localparam logic [1:0] ST_ERROR  = 2'd3;

  // error codes
  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_NOT_GZIP     = 4'd1;
  localparam logic [3:0] ERR_BAD_METHOD   = 4'd2;
  localparam logic [3:0] ERR_CRC          = 4'd3;
  localparam logic [3:0] ERR_SIZE         = 4'd4;
  localparam logic [3:0] ERR_TRUNC_HEADER = 4'd5;
  localparam logic [3:0] ERR_TRUNC_BODY   = 4'd6;
  localparam logic [3:0] ERR_TRUNC_TRAIL  = 4'd7;
  localparam logic [3:0] ERR_MISPLACED    = 4'd8;

  // framing phases
  localparam logic [3:0] PH_FIXED   = 4'd0;
  localparam logic [3:0] PH_XLEN    = 4'd1;
  localparam logic [3:0] PH_XDATA   = 4'd2;
  localparam logic [3:0] PH_NAME    = 4'd3;
  localparam logic [3:0] PH_COMMENT = 4'd4;
  localparam logic [3:0] PH_HCRC    = 4'd5;
  localparam logic [3:0] PH_BODY    = 4'd6;
  localparam logic [3:0] PH_TRAILER = 4'd7;
  localparam logic [3:0] PH_DONE    = 4'd8;

  // header constants
  localparam logic [7:0]  MAGIC_ID1     = 8'h1f;
  localparam logic [7:0]  MAGIC_ID2     = 8'h8b;
  localparam logic [7:0]  METHOD_DEFLATE = 8'h08;
  localparam logic [3:0]  FIXED_LEN     = 4'd10;
  localparam logic [3:0]  TRAILER_LEN   = 4'd8;
  localparam logic [3:0]  HCRC_LEN      = 4'd2;
  localparam logic [3:0]  XLEN_LEN      = 4'd2;

  // header_flags bit positions
  localparam int FL_HCRC    = 0;
  localparam int FL_EXTRA   = 1;
  localparam int FL_NAME    = 2;
  localparam int FL_COMMENT = 3;

  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;

endpackage

>>> src/gzmhc_crc32.sv
// ----------------------------------------------------------------------------
// gzmhc_crc32
// one-byte update of the reflected crc-32 used by the gzip trailer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gzmhc_crc32 (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [31:0] crc_out
);
  import gzmhc_pkg::*;

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data_in};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ {1'b0, c[31:1]}) : {1'b0, c[31:1]};
    end
    crc_out = c;
  end

endmodule

>>> src/gzmhc_frame.sv
// ----------------------------------------------------------------------------
// gzmhc_frame
// member framing state: header walk, payload crc and size, trailer check
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gzmhc_frame (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gzmhc_pkg::gzmhc_step_t step,
  output gzmhc_pkg::gzmhc_out_t  res
);
  import gzmhc_pkg::*;

  logic [3:0]  phase_r, phase_nxt;
  logic [3:0]  stage_count_r, stage_count_nxt;
  logic [3:0]  header_flags_r, header_flags_nxt;
  logic [15:0] extra_remaining_r, extra_remaining_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] payload_size_r, payload_size_nxt;
  logic [63:0] trailer_shift_r, trailer_shift_nxt;
  logic [3:0]  error_r, error_nxt;
  logic [31:0] crc_upd;

  gzmhc_crc32 u_crc (
    .crc_in  (crc_r),
    .data_in (step.item.data_byte),
    .crc_out (crc_upd)
  );

  // skip optional header parts whose flag is clear, and the extra data when its length is zero
  function automatic logic [3:0] next_phase(input logic [3:0] done,
                                            input logic [3:0] flags,
                                            input logic [15:0] extra);
    logic [3:0] p;
    p = done + 4'd1;
    if (p == PH_XLEN && !flags[FL_EXTRA]) p = PH_NAME;
    if (p == PH_XDATA && extra == 16'd0) p = PH_NAME;
    if (p == PH_NAME && !flags[FL_NAME]) p = PH_COMMENT;
    if (p == PH_COMMENT && !flags[FL_COMMENT]) p = PH_HCRC;
    if (p == PH_HCRC && !flags[FL_HCRC]) p = PH_BODY;
    return p;
  endfunction

  always_comb begin
    logic [1:0]  st;
    logic [7:0]  b;
    logic [3:0]  sc_inc;
    logic [3:0]  np;
    logic [3:0]  fl;
    logic [15:0] ext;
    logic [63:0] tsh;

    phase_nxt           = phase_r;
    stage_count_nxt     = stage_count_r;
    header_flags_nxt    = header_flags_r;
    extra_remaining_nxt = extra_remaining_r;
    crc_nxt             = crc_r;
    payload_size_nxt    = payload_size_r;
    trailer_shift_nxt   = trailer_shift_r;
    error_nxt           = error_r;
    st                  = ST_MORE;
    b                   = step.item.data_byte;
    sc_inc              = stage_count_r + 4'd1;
    np                  = PH_BODY;
    fl                  = header_flags_r;
    ext                 = extra_remaining_r;
    tsh                 = {b, trailer_shift_r[63:8]};

    if (error_r != ERR_NONE) begin
      st = ST_ERROR;
    end else if (phase_r == PH_DONE) begin
      st = ST_DONE;
    end else if (phase_r <= PH_HCRC) begin
      if (step.item.opcode == OP_CONTAINER) begin
        case (phase_r)
          PH_FIXED: begin
            if (stage_count_r < 4'd4) begin
              trailer_shift_nxt[8*stage_count_r[1:0] +: 8] = b;
            end
            stage_count_nxt = sc_inc;
            if (sc_inc == FIXED_LEN) begin
              if (trailer_shift_r[7:0] != MAGIC_ID1 || trailer_shift_r[15:8] != MAGIC_ID2)
                begin
                st        = ST_ERROR;
                error_nxt = ERR_NOT_GZIP;
              end else if (trailer_shift_r[23:16] != METHOD_DEFLATE) begin
                st        = ST_ERROR;
                error_nxt = ERR_BAD_METHOD;
              end else begin
                fl                = trailer_shift_r[28:25];
                header_flags_nxt  = fl;
                trailer_shift_nxt = 64'd0;
                np                = next_phase(PH_FIXED, fl, extra_remaining_r);
                phase_nxt         = np;
                stage_count_nxt   = 4'd0;
                st                = (np == PH_BODY) ? ST_HEADER : ST_MORE;
              end
            end
          end
          PH_XLEN: begin
            ext = extra_remaining_r;
            if (stage_count_r[0]) ext[15:8] = b;
            else ext[7:0] = b;
            extra_remaining_nxt = ext;
            stage_count_nxt     = sc_inc;
            if (sc_inc == XLEN_LEN) begin
              np              = next_phase(PH_XLEN, fl, ext);
              phase_nxt       = np;
              stage_count_nxt = 4'd0;
              st              = (np == PH_BODY) ? ST_HEADER : ST_MORE;
            end
          end
          PH_XDATA: begin
            ext                 = extra_remaining_r - 16'd1;
            extra_remaining_nxt = ext;
            if (ext == 16'd0) begin
              np              = next_phase(PH_XDATA, fl, ext);
              phase_nxt       = np;
              stage_count_nxt = 4'd0;
              st              = (np == PH_BODY) ? ST_HEADER : ST_MORE;
            end
          end
          PH_NAME, PH_COMMENT: begin
            // zero byte terminates the string
            if (b == 8'd0) begin
              np              = next_phase(phase_r, fl, extra_remaining_r);
              phase_nxt       = np;
              stage_count_nxt = 4'd0;
              st              = (np == PH_BODY) ? ST_HEADER : ST_MORE;
            end
          end
          default: begin
            stage_count_nxt = sc_inc;
            if (sc_inc == HCRC_LEN) begin
              np              = next_phase(PH_HCRC, fl, extra_remaining_r);
              phase_nxt       = np;
              stage_count_nxt = 4'd0;
              st              = (np == PH_BODY) ? ST_HEADER : ST_MORE;
            end
          end
        endcase
      end else if (step.item.opcode == OP_INPUT_END) begin
        st        = ST_ERROR;
        error_nxt = ERR_TRUNC_HEADER;
      end else begin
        st        = ST_ERROR;
        error_nxt = ERR_MISPLACED;
      end
    end else if (phase_r == PH_BODY) begin
      case (step.item.opcode)
        OP_PAYLOAD: begin
          crc_nxt          = crc_upd;
          payload_size_nxt = payload_size_r + 32'd1;
        end
        OP_BODY_END: begin
          phase_nxt         = PH_TRAILER;
          stage_count_nxt   = 4'd0;
          trailer_shift_nxt = 64'd0;
        end
        OP_INPUT_END: begin
          st        = ST_ERROR;
          error_nxt = ERR_TRUNC_BODY;
        end
        default: begin
          // container bytes in the body belong to the inflater
          st = ST_MORE;
        end
      endcase
    end else if (phase_r == PH_TRAILER) begin
      if (step.item.opcode == OP_CONTAINER) begin
        trailer_shift_nxt = tsh;
        stage_count_nxt   = sc_inc;
        if (sc_inc >= TRAILER_LEN) begin
          if (tsh[31:0] != ~crc_r) begin
            st        = ST_ERROR;
            error_nxt = ERR_CRC;
          end else if (tsh[63:32] != payload_size_r) begin
            st        = ST_ERROR;
            error_nxt = ERR_SIZE;
          end else begin
            phase_nxt = PH_DONE;
            st        = ST_DONE;
          end
        end
      end else if (step.item.opcode == OP_INPUT_END) begin
        st        = ST_ERROR;
        error_nxt = ERR_TRUNC_TRAIL;
      end else begin
        st        = ST_ERROR;
        error_nxt = ERR_MISPLACED;
      end
    end else begin
      st        = ST_ERROR;
      error_nxt = ERR_MISPLACED;
    end

    res.status     = st;
    res.error_code = (st == ST_ERROR) ? error_nxt : ERR_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= PH_FIXED;
      stage_count_r     <= 4'd0;
      header_flags_r    <= 4'd0;
      extra_remaining_r <= 16'd0;
      crc_r             <= CRC_PRESET;
      payload_size_r    <= 32'd0;
      trailer_shift_r   <= 64'd0;
      error_r           <= ERR_NONE;
    end else if (step.fire) begin
      phase_r           <= phase_nxt;
      stage_count_r     <= stage_count_nxt;
      header_flags_r    <= header_flags_nxt;
      extra_remaining_r <= extra_remaining_nxt;
      crc_r             <= crc_nxt;
      payload_size_r    <= payload_size_nxt;
      trailer_shift_r   <= trailer_shift_nxt;
      error_r           <= error_nxt;
    end
  end

endmodule

>>> src/gzip_member_header_trailer_checker.sv
// ----------------------------------------------------------------------------
// gzip_member_header_trailer_checker
// gzip member framing check around an external deflate engine
// ----------------------------------------------------------------------------
// Takes one request per clock while in_stall is low: container bytes, inflated
// payload bytes, body-end and end-of-input events, and returns one status per
// request. A request is captured in an input register, evaluated against the
// framing state (header walk, bytewise crc-32 update, trailer compare) and its
// result lands in an output register. Throughput is one request per cycle while
// out_stall does not hold the output, as the byte crc and next-state logic in the
// framing stage are combinational.
// Errors are sticky until reset; after a good trailer every request answers
// done.
`timescale 1ns / 1ps
`include "gzip_member_header_trailer_checker_defines.svh"

module gzip_member_header_trailer_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  gzmhc_pkg::gzmhc_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output gzmhc_pkg::gzmhc_out_t out_data
);
  import gzmhc_pkg::*;

  logic        in_valid_r;
  gzmhc_in_t   in_data_r;
  logic        out_valid_r;
  gzmhc_out_t  out_data_r;
  logic        advance;
  gzmhc_step_t step;
  gzmhc_out_t  res;

  // request moves into the result register when that register frees up
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;

  assign step.fire = advance;
  assign step.item = in_data_r;

  gzmhc_frame u_frame (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `GZMHC_ASSERT_NOW(a_code_matches_status, out_valid, ((out_data.status == ST_ERROR) == (out_data.error_code != ERR_NONE)), "error code disagrees with status")
  `GZMHC_ASSERT_NEXT(a_advance_fills_out, advance, out_valid, "advanced request did not reach output")
  `GZMHC_ASSERT_NOW(a_stall_only_when_full, !in_valid_r, !in_stall, "input stalled while input register empty")

endmodule
